// ===== hdl/chkvt_pkg.sv =====
// Package for the chained hash key/value table.
// Holds the transaction structs, opcode and result codes, hash constants and the
// controller/datapath command and status structs. No dependencies.
package chkvt_pkg;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  localparam logic [1:0] RC_DONE   = 2'd0;
  localparam logic [1:0] RC_ABSENT = 2'd1;
  localparam logic [1:0] RC_DUP    = 2'd2;
  localparam logic [1:0] RC_FULL   = 2'd3;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  localparam int unsigned LIMIT_W   = 9;
  localparam logic [8:0]  LIMIT_RST = 9'd192;

  // accumulator operations on the registered partial product
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  // partial product selects
  localparam logic [1:0] PP_LL = 2'd0;
  localparam logic [1:0] PP_HL = 2'd1;
  localparam logic [1:0] PP_LH = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [63:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic       accept;
    logic       mul_c;
    logic [1:0] mul_sel;
    logic [1:0] acc_op;
    logic       mix2;
    logic       hash;
    logic       head_rd;
    logic       head_ld;
    logic       node_rd;
    logic       node_chk;
    logic       act;
    logic       pop_rd;
    logic       ins;
    logic       clear;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic head_ok;
    logic match;
    logic link_ok;
    logic ins_ok;
    logic fsp_nz;
  } sts_t;

endpackage

// ===== hdl/chained_hash_key_value_table.sv =====
// Chained hash key/value table: 64-bit keys to 64-bit values.
// Instantiates chkvt_ctrl and chkvt_dpath; depends on chkvt_pkg.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one operation per
//   transaction: set, add, lookup or remove. Result channel out_valid/
//   out_stall/out_data returns exactly one result transaction per operation,
//   in order. cfg_wr_en/cfg_wr_data write the entry limit; write it only while
//   the block is idle.
//   One operation at a time. The time from acceptance to out_valid and
//   between acceptances grows with each chain node visited and with an
//   insert; it is set by the two 64-bit hash multiplies, each folded from three
//   32x32 partial products on one shared multiplier, and by the node walk.
//   A new operation is accepted as soon as the previous one has been placed
//   in the output register, even while that result still waits.
//   After reset the bucket head memory is swept empty, one bucket per cycle,
//   all BUCKETS heads, with in_stall held high; configuration writes still land.
//   When the receiver stalls, hold the result; the next operation completes
//   but waits in the controller until the output register is free.
//   BUCKETS must be a power of two (the bucket is the low bits of the hash).
module chained_hash_key_value_table #(
  parameter int unsigned BUCKETS    = 64,
  parameter int unsigned POOL_NODES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  chkvt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output chkvt_pkg::out_item_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [8:0]           cfg_wr_data
);

  chkvt_pkg::cmd_t cmd;
  chkvt_pkg::sts_t sts;

  chkvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  chkvt_dpath #(
    .BUCKETS    (BUCKETS),
    .POOL_NODES (POOL_NODES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

`ifndef NO_ASSERTIONS
  // an accepted transaction keeps the input side closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // reset starts the head clearing sweep with the input closed
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open straight after reset");

  // only a successful lookup returns a value
  a_value_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_code != chkvt_pkg::RC_DONE) |-> (out_data.read_value == 64'h0))
    else $error("value returned with a failure code");
`endif

endmodule

// ===== hdl/chkvt_ctrl.sv =====
// Controller state machine for the chained hash key/value table.
// Depends on chkvt_pkg (command and status structs, accumulator codes).
module chkvt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  chkvt_pkg::sts_t  sts,
  output chkvt_pkg::cmd_t  cmd
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_M1    = 4'd2;
  localparam logic [3:0] ST_MIX   = 4'd3;
  localparam logic [3:0] ST_M2    = 4'd4;
  localparam logic [3:0] ST_HASH  = 4'd5;
  localparam logic [3:0] ST_HREAD = 4'd6;
  localparam logic [3:0] ST_HWAIT = 4'd7;
  localparam logic [3:0] ST_NREAD = 4'd8;
  localparam logic [3:0] ST_NCHK  = 4'd9;
  localparam logic [3:0] ST_ACT   = 4'd10;
  localparam logic [3:0] ST_POP   = 4'd11;
  localparam logic [3:0] ST_INS   = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [1:0] mc_r, mc_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    mc_nxt        = mc_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          mc_nxt     = 2'd0;
          state_nxt  = ST_M1;
        end
      end
      ST_M1, ST_M2: begin
        // issue one partial product a cycle, fold the previous one in
        cmd.mul_c   = (state_r == ST_M2);
        cmd.mul_sel = mc_r;
        cmd.acc_op  = (mc_r == 2'd0) ? chkvt_pkg::ACC_NONE :
                      (mc_r == 2'd1) ? chkvt_pkg::ACC_LOAD : chkvt_pkg::ACC_ADD;
        mc_nxt      = mc_r + 2'd1;
        if (mc_r == 2'd3) state_nxt = (state_r == ST_M1) ? ST_MIX : ST_HASH;
      end
      ST_MIX: begin
        cmd.mix2  = 1'b1;
        mc_nxt    = 2'd0;
        state_nxt = ST_M2;
      end
      ST_HASH: begin
        cmd.hash  = 1'b1;
        state_nxt = ST_HREAD;
      end
      ST_HREAD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = ST_HWAIT;
      end
      ST_HWAIT: begin
        cmd.head_ld = 1'b1;
        state_nxt   = sts.head_ok ? ST_NREAD : ST_ACT;
      end
      ST_NREAD: begin
        cmd.node_rd = 1'b1;
        state_nxt   = ST_NCHK;
      end
      ST_NCHK: begin
        cmd.node_chk = 1'b1;
        if (sts.match)        state_nxt = ST_ACT;
        else if (sts.link_ok) state_nxt = ST_NREAD;
        else                  state_nxt = ST_ACT;
      end
      ST_ACT: begin
        cmd.act = 1'b1;
        if (sts.ins_ok) state_nxt = sts.fsp_nz ? ST_POP : ST_INS;
        else            state_nxt = ST_OUT;
      end
      ST_POP: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = ST_INS;
      end
      ST_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hand over only once the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      mc_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mc_r        <= mc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/chkvt_dpath.sv =====
// Datapath for the chained hash key/value table: hash multiplier, bucket head
// memory, node memories, free node stack, counters and result registers.
// Depends on chkvt_pkg.
module chkvt_dpath #(
  parameter int unsigned BUCKETS    = 64,
  parameter int unsigned POOL_NODES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  chkvt_pkg::cmd_t      cmd,
  output chkvt_pkg::sts_t      sts,
  input  chkvt_pkg::in_item_t  in_data,
  input  logic                 cfg_wr_en,
  input  logic [8:0]           cfg_wr_data,
  output chkvt_pkg::out_item_t out_data
);

  localparam int unsigned BKT_W = $clog2(BUCKETS);
  localparam int unsigned NODE_W = $clog2(POOL_NODES);
  localparam int unsigned CNT_W = NODE_W + 1;
  localparam int unsigned CMP_W = (CNT_W > chkvt_pkg::LIMIT_W) ? CNT_W : chkvt_pkg::LIMIT_W;
  localparam int unsigned LNK_W = NODE_W + 1;

  // memories
  logic [LNK_W-1:0]  head_mem  [BUCKETS];
  logic [63:0]       key_mem   [POOL_NODES];
  logic [63:0]       val_mem   [POOL_NODES];
  logic [LNK_W-1:0]  link_mem  [POOL_NODES];
  logic [NODE_W-1:0] free_mem  [POOL_NODES];

  logic [1:0]        op_r;
  logic [63:0]       key_r, val_r, a_r, acc_r, prod_r;
  logic [BKT_W-1:0]  bucket_r, clr_r;
  logic              found_r, prev_ok_r, head_ok_r;
  logic [NODE_W-1:0] cur_r, prev_r, head_idx_r, pop_r;
  logic [LNK_W-1:0]  head_rd_r, link_rd_r;
  logic [63:0]       key_rd_r, val_rd_r;
  logic [CNT_W-1:0]  count_r, fsp_r, fresh_r;
  logic [8:0]        limit_r;
  logic [1:0]        res_code_r;
  logic [63:0]       res_val_r;

  logic [31:0]       a_half, c_half;
  logic [63:0]       c_sel, hash_val;
  logic [CMP_W-1:0]  count_x, limit_x, pool_x;
  logic              ins_ok, is_ins_op;
  logic [NODE_W-1:0] alloc_idx;

  // head memory write port
  logic              head_we;
  logic [BKT_W-1:0]  head_wa;
  logic [LNK_W-1:0]  head_wd;

  assign c_sel  = cmd.mul_c ? chkvt_pkg::MIX_C2 : chkvt_pkg::MIX_C1;
  assign a_half = (cmd.mul_sel == chkvt_pkg::PP_HL) ? a_r[63:32] : a_r[31:0];
  assign c_half = (cmd.mul_sel == chkvt_pkg::PP_LH) ? c_sel[63:32] : c_sel[31:0];
  assign hash_val = acc_r ^ (acc_r >> 31);

  assign count_x = CMP_W'(count_r);
  assign limit_x = CMP_W'(limit_r);
  assign pool_x  = CMP_W'(POOL_NODES);
  assign is_ins_op = (op_r == chkvt_pkg::OP_SET) || (op_r == chkvt_pkg::OP_ADD);
  assign ins_ok  = is_ins_op && !found_r && (count_x < limit_x) && (count_x < pool_x);
  assign alloc_idx = (fsp_r != '0) ? pop_r : fresh_r[NODE_W-1:0];

  assign sts.clr_last = (clr_r == BKT_W'(BUCKETS - 1));
  assign sts.head_ok  = head_rd_r[NODE_W];
  assign sts.match    = (key_rd_r == key_r);
  assign sts.link_ok  = link_rd_r[NODE_W];
  assign sts.ins_ok   = ins_ok;
  assign sts.fsp_nz   = (fsp_r != '0);

  always_comb begin
    head_we = 1'b0;
    head_wa = bucket_r;
    head_wd = link_rd_r;
    if (cmd.clear) begin
      head_we = 1'b1;
      head_wa = clr_r;
      head_wd = '0;
    end else if (cmd.act && op_r == chkvt_pkg::OP_REMOVE && found_r && !prev_ok_r) begin
      head_we = 1'b1;
    end else if (cmd.ins) begin
      head_we = 1'b1;
      head_wd = {1'b1, alloc_idx};
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (cmd.head_rd) head_rd_r <= head_mem[bucket_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      key_mem[alloc_idx] <= key_r;
      val_mem[alloc_idx] <= val_r;
    end else if (cmd.act && op_r == chkvt_pkg::OP_SET && found_r) begin
      val_mem[cur_r] <= val_r;
    end
    if (cmd.ins) begin
      link_mem[alloc_idx] <= {head_ok_r, head_idx_r};
    end else if (cmd.act && op_r == chkvt_pkg::OP_REMOVE && found_r && prev_ok_r) begin
      link_mem[prev_r] <= link_rd_r;
    end
    if (cmd.act && op_r == chkvt_pkg::OP_REMOVE && found_r) begin
      free_mem[fsp_r[NODE_W-1:0]] <= cur_r;
    end
    if (cmd.node_rd) begin
      key_rd_r  <= key_mem[cur_r];
      val_rd_r  <= val_mem[cur_r];
      link_rd_r <= link_mem[cur_r];
    end
    if (cmd.pop_rd) begin
      pop_r <= free_mem[NODE_W'(fsp_r - CNT_W'(1))];
    end
  end

  // hash, walk and result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_data.opcode;
      key_r <= in_data.key;
      val_r <= in_data.value;
      a_r   <= in_data.key ^ (in_data.key >> 30);
    end else if (cmd.mix2) begin
      a_r <= acc_r ^ (acc_r >> 27);
    end
    prod_r <= 64'(a_half) * 64'(c_half);
    case (cmd.acc_op)
      chkvt_pkg::ACC_LOAD: acc_r <= prod_r;
      chkvt_pkg::ACC_ADD:  acc_r <= acc_r + {prod_r[31:0], 32'h0};
      default:             acc_r <= acc_r;
    endcase
    if (cmd.hash) bucket_r <= hash_val[BKT_W-1:0];
    if (cmd.head_ld) begin
      cur_r      <= head_rd_r[NODE_W-1:0];
      head_ok_r  <= head_rd_r[NODE_W];
      head_idx_r <= head_rd_r[NODE_W-1:0];
      prev_ok_r  <= 1'b0;
    end else if (cmd.node_chk && !sts.match) begin
      prev_ok_r <= 1'b1;
      prev_r    <= cur_r;
      cur_r     <= link_rd_r[NODE_W-1:0];
    end
    if (cmd.act) begin
      res_val_r <= (op_r == chkvt_pkg::OP_LOOKUP && found_r) ? val_rd_r : 64'h0;
      case (op_r)
        chkvt_pkg::OP_LOOKUP: res_code_r <= found_r ? chkvt_pkg::RC_DONE : chkvt_pkg::RC_ABSENT;
        chkvt_pkg::OP_REMOVE: res_code_r <= found_r ? chkvt_pkg::RC_DONE : chkvt_pkg::RC_ABSENT;
        chkvt_pkg::OP_ADD:    res_code_r <= found_r ? chkvt_pkg::RC_DUP :
                                            (ins_ok ? chkvt_pkg::RC_DONE : chkvt_pkg::RC_FULL);
        default:              res_code_r <= (found_r || ins_ok) ? chkvt_pkg::RC_DONE :
                                            chkvt_pkg::RC_FULL;
      endcase
    end
    if (cmd.out_load) begin
      out_data.result_code <= res_code_r;
      out_data.read_value  <= res_val_r;
    end
  end

  // control state: counters, found flag, limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      found_r <= 1'b0;
      count_r <= '0;
      fsp_r   <= '0;
      fresh_r <= '0;
      limit_r <= chkvt_pkg::LIMIT_RST;
    end else begin
      if (cmd.clear) clr_r <= clr_r + BKT_W'(1);
      if (cmd.accept) found_r <= 1'b0;
      else if (cmd.node_chk && sts.match) found_r <= 1'b1;
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (cmd.act && op_r == chkvt_pkg::OP_REMOVE && found_r) begin
        count_r <= count_r - CNT_W'(1);
        fsp_r   <= fsp_r + CNT_W'(1);
      end else if (cmd.ins) begin
        count_r <= count_r + CNT_W'(1);
        if (fsp_r != '0) fsp_r <= fsp_r - CNT_W'(1);
        else             fresh_r <= fresh_r + CNT_W'(1);
      end
    end
  end

endmodule
